[hdl/rcstc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the stick and throttle curve block.
// No dependencies; every other file of the block imports this package.
package rcstc_pkg;

  // Register index codes on the configuration port.
  localparam logic [2:0] CFG_RC_RATE       = 3'd0;
  localparam logic [2:0] CFG_RC_EXPO       = 3'd1;
  localparam logic [2:0] CFG_THROTTLE_MID  = 3'd2;
  localparam logic [2:0] CFG_THROTTLE_EXPO = 3'd3;
  localparam logic [2:0] CFG_MIN_THROTTLE  = 3'd4;

  // Curve constants.
  localparam logic [10:0] MAX_THROTTLE  = 11'd1850;
  localparam logic [10:0] PR_BASE       = 11'd1526;
  localparam logic [10:0] PR_DIV        = 11'd1192;
  localparam logic [6:0]  THR_STEP      = 7'd10;
  localparam logic [6:0]  THR_PCT       = 7'd100;
  localparam logic [9:0]  THR_SPAN      = 10'd1000;
  localparam logic [3:0]  PR_MAX_INDEX  = 4'd4;
  localparam logic [3:0]  THR_MAX_INDEX = 4'd10;
  localparam logic [10:0] VALUE_MAX     = 11'd2047;

  // Reciprocals for the constant divisions: q ~ (x * RECIP) >> SHIFT, then one correction.
  localparam logic [13:0] PR_RECIP      = 14'd14074;
  localparam int          PR_SHIFT      = 24;
  localparam logic [13:0] DIV10_RECIP   = 14'd13107;
  localparam int          DIV10_SHIFT   = 17;
  localparam logic [22:0] DIV1000_RECIP = 23'd4294967;
  localparam int          DIV1000_SHIFT = 32;

  // Widths of the throttle expo divider.
  localparam int DIV_NUM_W = 21;
  localparam int DIV_DEN_W = 14;
  localparam int QUO_W     = 7;

  // Clock edges from the accepting edge to the edge that takes the result.
  localparam int LATENCY = 17;

  typedef struct packed {
    logic       op;
    logic [3:0] point_index;
  } rcstc_in_t;

  typedef struct packed {
    logic [10:0] curve_value;
    logic        index_error;
  } rcstc_out_t;

  typedef struct packed {
    logic [7:0]  rc_rate;
    logic [6:0]  rc_expo;
    logic [6:0]  throttle_mid;
    logic [6:0]  throttle_expo;
    logic [10:0] min_throttle;
  } rcstc_cfg_t;

  localparam rcstc_cfg_t CFG_RESET = '{
    rc_rate:       8'd90,
    rc_expo:       7'd65,
    throttle_mid:  7'd50,
    throttle_expo: 7'd0,
    min_throttle:  11'd1150
  };

  // One item on its way through the expo divider, with the pitch/roll lane alongside.
  typedef struct packed {
    logic                  op;
    logic                  err;
    logic signed [8:0]     t;
    logic signed [21:0]    pr_prod;
    logic [DIV_NUM_W-1:0]  rem;
    logic [DIV_DEN_W-1:0]  den;
    logic [QUO_W-1:0]      quo;
  } rcstc_div_beat_t;

  // Pitch/roll breakpoint offset i*i - 15 for indexes 0 to 4.
  function automatic logic signed [4:0] pr_offset(logic [2:0] i);
    logic signed [4:0] k;
    case (i)
      3'd0:    k = -5'sd15;
      3'd1:    k = -5'sd14;
      3'd2:    k = -5'sd11;
      3'd3:    k = -5'sd6;
      3'd4:    k = 5'sd1;
      default: k = 5'sd0;
    endcase
    return k;
  endfunction

  // One restoring division step for quotient bit bit_pos.
  function automatic rcstc_div_beat_t div_step(rcstc_div_beat_t b, int unsigned bit_pos);
    rcstc_div_beat_t      r;
    logic [DIV_NUM_W-1:0] trial;
    r = b;
    trial = DIV_NUM_W'(b.den) << bit_pos;
    if (b.rem >= trial) begin
      r.rem = b.rem - trial;
      r.quo[bit_pos] = 1'b1;
    end
    return r;
  endfunction

endpackage

[hdl/rcstc_front.sv]
`timescale 1ns / 1ps
// Front end: input register and the two product stages that set up both curve lanes.
// Depends on rcstc_pkg.
module rcstc_front import rcstc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  rcstc_in_t       in_item,
  input  rcstc_cfg_t      cfg,
  output logic            out_valid,
  output rcstc_div_beat_t out_beat
);

  logic      s0_valid;
  rcstc_in_t s0_item;

  logic                s1_valid;
  logic                s1_op;
  logic                s1_err;
  logic signed [8:0]   s1_t;
  logic [13:0]         s1_tsq;
  logic [13:0]         s1_ysq;
  logic signed [11:0]  s1_pr_a;
  logic [9:0]          s1_pr_ir;

  logic [3:0]          thr_idx;
  logic [6:0]          thr_pos;
  logic signed [8:0]   t_c;
  logic [6:0]          t_abs;
  logic [6:0]          y_c;
  logic [2:0]          pr_i;
  logic signed [12:0]  pr_a_c;
  logic [DIV_NUM_W-1:0] num_c;
  logic signed [21:0]  pr_prod_c;

  // Valid bits of the three front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s0_valid  <= in_valid;
      s1_valid  <= s0_valid;
      out_valid <= s1_valid;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    s0_item <= in_item;
  end

  // Stage one: signed distance from the midpoint, its bend span, and the pitch/roll base term.
  always_comb begin
    thr_idx = (s0_item.point_index > THR_MAX_INDEX) ? THR_MAX_INDEX : s0_item.point_index;
    thr_pos = 7'(thr_idx) * THR_STEP;
    t_c     = $signed({2'b00, thr_pos}) - $signed({2'b00, cfg.throttle_mid});
    t_abs   = t_c[8] ? 7'(-t_c) : 7'(t_c);
    if (t_c > 9'sd0) begin
      y_c = THR_PCT - cfg.throttle_mid;
    end else if (t_c < 9'sd0) begin
      y_c = cfg.throttle_mid;
    end else begin
      y_c = 7'd1;
    end
    if (y_c == 7'd0) begin
      y_c = 7'd1;
    end
    pr_i   = s0_item.point_index[2:0];
    pr_a_c = $signed({2'b00, PR_BASE}) + $signed({1'b0, cfg.rc_expo}) * pr_offset(pr_i);
  end

  always_ff @(posedge clk) begin
    s1_op    <= s0_item.op;
    s1_err   <= !s0_item.op && (s0_item.point_index > PR_MAX_INDEX);
    s1_t     <= t_c;
    s1_tsq   <= 14'(t_abs) * 14'(t_abs);
    s1_ysq   <= 14'(y_c) * 14'(y_c);
    s1_pr_a  <= pr_a_c[11:0];
    s1_pr_ir <= 10'(pr_i) * 10'(cfg.rc_rate);
  end

  // Stage two: expo numerator and the full pitch/roll product.
  always_comb begin
    num_c     = DIV_NUM_W'(cfg.throttle_expo) * DIV_NUM_W'(s1_tsq);
    pr_prod_c = s1_pr_a * $signed({1'b0, s1_pr_ir});
  end

  always_ff @(posedge clk) begin
    out_beat.op      <= s1_op;
    out_beat.err     <= s1_err;
    out_beat.t       <= s1_t;
    out_beat.pr_prod <= pr_prod_c;
    out_beat.rem     <= num_c;
    out_beat.den     <= s1_ysq;
    out_beat.quo     <= '0;
  end

endmodule

[hdl/rcstc_divider.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider for the throttle expo ratio, one quotient bit per stage.
// Depends on rcstc_pkg.
module rcstc_divider import rcstc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  rcstc_div_beat_t in_beat,
  output logic            out_valid,
  output rcstc_div_beat_t out_beat
);

  rcstc_div_beat_t  stage_beat [QUO_W];
  rcstc_div_beat_t  nxt_beat   [QUO_W];
  logic [QUO_W-1:0] stage_vld;

  // Each stage settles one quotient bit, most significant first.
  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    if (s == 0) begin : g_head
      assign nxt_beat[s] = div_step(in_beat, QUO_W - 1 - s);
    end else begin : g_body
      assign nxt_beat[s] = div_step(stage_beat[s-1], QUO_W - 1 - s);
    end
  end

  always_ff @(posedge clk) begin
    stage_beat <= nxt_beat;
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
    end else begin
      stage_vld <= {stage_vld[QUO_W-2:0], in_valid};
    end
  end

  assign out_valid = stage_vld[QUO_W-1];
  assign out_beat  = stage_beat[QUO_W-1];

endmodule

[hdl/rcstc_back.sv]
`timescale 1ns / 1ps
// Back end: throttle bend, the divisions by constants, rescaling, clamping and the result register.
// Depends on rcstc_pkg.
module rcstc_back import rcstc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  rcstc_cfg_t      cfg,
  input  logic            in_valid,
  input  rcstc_div_beat_t in_beat,
  output logic            out_valid,
  output rcstc_out_t      out_result
);

  logic [5:0] vld;

  logic               s1_op, s1_err;
  logic signed [14:0] s1_tm;
  logic [20:0]        s1_pr_x;
  logic [10:0]        s1_pr_est;

  logic               s2_op, s2_err;
  logic [10:0]        s2_pr_val;
  logic               s2_neg;
  logic [13:0]        s2_mag;
  logic [10:0]        s2_est;

  logic               s3_op, s3_err;
  logic [10:0]        s3_pr_val;
  logic signed [11:0] s3_p;

  logic               s4_op, s4_err;
  logic [10:0]        s4_pr_val;
  logic signed [22:0] s4_prod;

  logic               s5_op, s5_err;
  logic [10:0]        s5_pr_val;
  logic               s5_neg;
  logic [21:0]        s5_mag;
  logic [11:0]        s5_est;

  logic               s6_op, s6_err;
  logic [10:0]        s6_pr_val;
  logic signed [12:0] s6_sv;

  logic signed [8:0]  m_c;
  logic signed [17:0] tm_c;
  logic [20:0]        pr_pos;
  logic [34:0]        pr_est_full;
  logic [21:0]        pr_rem;
  logic [11:0]        pr_quo;
  logic [10:0]        pr_val_c;
  logic               tm_neg;
  logic [13:0]        tm_mag;
  logic [27:0]        tm_prod;
  logic [14:0]        r10;
  logic [10:0]        q10;
  logic signed [11:0] sq10;
  logic [10:0]        mid10;
  logic signed [11:0] p_c;
  logic signed [11:0] diff_c;
  logic signed [23:0] prod_c;
  logic               sc_neg;
  logic [21:0]        sc_mag;
  logic [44:0]        sc_prod;
  logic [22:0]        r1000;
  logic [11:0]        q1000;
  logic signed [12:0] sv_c;
  logic signed [13:0] sum_c;
  logic [10:0]        thr_val;

  // Valid bits of the six working stages and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[4:0], in_valid};
      out_valid <= vld[5];
    end
  end

  // Stage one: bend factor times distance; reciprocal estimate of the pitch/roll quotient.
  always_comb begin
    m_c = 9'sd100 - $signed({2'b00, cfg.throttle_expo}) + $signed({2'b00, in_beat.quo});
    tm_c = $signed(in_beat.t) * m_c;
    // A negative pitch/roll product always ends at zero after clamping.
    pr_pos = in_beat.pr_prod[21] ? 21'd0 : in_beat.pr_prod[20:0];
    pr_est_full = 35'(pr_pos) * 35'(PR_RECIP);
  end

  always_ff @(posedge clk) begin
    s1_op     <= in_beat.op;
    s1_err    <= in_beat.err;
    s1_tm     <= tm_c[14:0];
    s1_pr_x   <= pr_pos;
    s1_pr_est <= pr_est_full[PR_SHIFT +: 11];
  end

  // Stage two: correct the pitch/roll quotient; estimate the division by ten.
  always_comb begin
    pr_rem = {1'b0, s1_pr_x} - 22'(s1_pr_est) * 22'(PR_DIV);
    pr_quo = (pr_rem >= 22'(PR_DIV)) ? 12'(s1_pr_est) + 12'd1 : 12'(s1_pr_est);
    pr_val_c = (pr_quo > 12'(VALUE_MAX)) ? VALUE_MAX : pr_quo[10:0];
    tm_neg = s1_tm[14];
    tm_mag = tm_neg ? 14'(-s1_tm) : 14'(s1_tm);
    tm_prod = 28'(tm_mag) * 28'(DIV10_RECIP);
  end

  always_ff @(posedge clk) begin
    s2_op     <= s1_op;
    s2_err    <= s1_err;
    s2_pr_val <= pr_val_c;
    s2_neg    <= tm_neg;
    s2_mag    <= tm_mag;
    s2_est    <= tm_prod[DIV10_SHIFT +: 11];
  end

  // Stage three: correct the division by ten, restore the sign and add the midpoint.
  always_comb begin
    r10   = {1'b0, s2_mag} - 15'(s2_est) * 15'(THR_STEP);
    q10   = (r10 >= 15'(THR_STEP)) ? s2_est + 11'd1 : s2_est;
    sq10  = s2_neg ? -$signed({1'b0, q10}) : $signed({1'b0, q10});
    mid10 = 11'(cfg.throttle_mid) * 11'(THR_STEP);
    p_c   = $signed({1'b0, mid10}) + sq10;
  end

  always_ff @(posedge clk) begin
    s3_op     <= s2_op;
    s3_err    <= s2_err;
    s3_pr_val <= s2_pr_val;
    s3_p      <= p_c;
  end

  // Stage four: scale the point by the throttle span.
  always_comb begin
    diff_c = $signed({1'b0, MAX_THROTTLE}) - $signed({1'b0, cfg.min_throttle});
    prod_c = diff_c * s3_p;
  end

  always_ff @(posedge clk) begin
    s4_op     <= s3_op;
    s4_err    <= s3_err;
    s4_pr_val <= s3_pr_val;
    s4_prod   <= prod_c[22:0];
  end

  // Stage five: reciprocal estimate of the division by one thousand on the magnitude.
  always_comb begin
    sc_neg  = s4_prod[22];
    sc_mag  = sc_neg ? 22'(-s4_prod) : 22'(s4_prod);
    sc_prod = 45'(sc_mag) * 45'(DIV1000_RECIP);
  end

  always_ff @(posedge clk) begin
    s5_op     <= s4_op;
    s5_err    <= s4_err;
    s5_pr_val <= s4_pr_val;
    s5_neg    <= sc_neg;
    s5_mag    <= sc_mag;
    s5_est    <= sc_prod[DIV1000_SHIFT +: 12];
  end

  // Stage six: correct the quotient and restore its sign.
  always_comb begin
    r1000 = {1'b0, s5_mag} - 23'(s5_est) * 23'(THR_SPAN);
    q1000 = (r1000 >= 23'(THR_SPAN)) ? s5_est + 12'd1 : s5_est;
    sv_c  = s5_neg ? -$signed({1'b0, q1000}) : $signed({1'b0, q1000});
  end

  always_ff @(posedge clk) begin
    s6_op     <= s5_op;
    s6_err    <= s5_err;
    s6_pr_val <= s5_pr_val;
    s6_sv     <= sv_c;
  end

  // Result register: add the minimum throttle, clamp, and pick the lane.
  always_comb begin
    sum_c = $signed({3'b000, cfg.min_throttle}) + s6_sv;
    if (sum_c < 14'sd0) begin
      thr_val = 11'd0;
    end else if (sum_c > $signed({3'b000, VALUE_MAX})) begin
      thr_val = VALUE_MAX;
    end else begin
      thr_val = sum_c[10:0];
    end
  end

  always_ff @(posedge clk) begin
    out_result.index_error <= s6_err;
    if (s6_op) begin
      out_result.curve_value <= thr_val;
    end else if (s6_err) begin
      out_result.curve_value <= 11'd0;
    end else begin
      out_result.curve_value <= s6_pr_val;
    end
  end

endmodule

[hdl/rc_stick_and_throttle_curve.sv]
`timescale 1ns / 1ps
// Throughput: one item per cycle; busy is low except during reset.
// The 17 stages are three front stages, the seven-stage expo divider and seven back stages.
// Reset is synchronous: it empties the pipeline and restores the register defaults.
// The receiver cannot stall, so done follows accepted items one to one.
// Depends on rcstc_pkg, rcstc_front, rcstc_divider and rcstc_back.
module rc_stick_and_throttle_curve import rcstc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  rcstc_in_t   item,
  output logic        busy,
  output logic        done,
  output rcstc_out_t  result,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  rcstc_cfg_t      cfg;
  logic            in_valid;
  logic            front_valid;
  rcstc_div_beat_t front_beat;
  logic            div_valid;
  rcstc_div_beat_t div_beat;

  assign busy     = rst;
  assign in_valid = start && !busy;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RC_RATE:       cfg.rc_rate       <= cfg_data[7:0];
        CFG_RC_EXPO:       cfg.rc_expo       <= cfg_data[6:0];
        CFG_THROTTLE_MID:  cfg.throttle_mid  <= cfg_data[6:0];
        CFG_THROTTLE_EXPO: cfg.throttle_expo <= cfg_data[6:0];
        CFG_MIN_THROTTLE:  cfg.min_throttle  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  rcstc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_item   (item),
    .cfg       (cfg),
    .out_valid (front_valid),
    .out_beat  (front_beat)
  );

  rcstc_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_beat   (front_beat),
    .out_valid (div_valid),
    .out_beat  (div_beat)
  );

  rcstc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (div_valid),
    .in_beat    (div_beat),
    .out_valid  (done),
    .out_result (result)
  );

endmodule

[hdl/rcstc_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the curve block, attached to the top level by a bind.
// Depends on rcstc_pkg and rc_stick_and_throttle_curve.
module rcstc_checker import rcstc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input rcstc_in_t  item,
  input logic       done,
  input rcstc_out_t result
);

  // Reset empties the pipeline.
  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("result beat right after reset");

  // Every accepted beat yields a result beat after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("no result beat at the expected latency");

  // A pitch/roll index above four is flagged with a zero value.
  a_pr_flag: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !item.op && item.point_index > PR_MAX_INDEX)
      |-> ##LATENCY (done && result.index_error && result.curve_value == 11'd0))
    else $error("bad pitch/roll index not flagged");

  // Throttle points are never flagged.
  a_thr_noflag: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.op) |-> ##LATENCY (done && !result.index_error))
    else $error("throttle point flagged");

endmodule

bind rc_stick_and_throttle_curve rcstc_checker u_rcstc_checker (.*);
